FILE: rtl/hgc_pkg.sv
`default_nettype none
package hgc_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int MAX_VERTICES = 9;
   localparam int PLANE_COUNT  = 6;
   localparam int T_FRAC       = 62 - COORD_WIDTH;
   localparam int IDX_W        = $clog2(MAX_VERTICES + 1);
   localparam int PLANE_W      = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COORD_WIDTH:0]   dist_type;
   typedef logic [IDX_W-1:0]              idx_type;
   typedef logic [PLANE_W-1:0]            plane_type;

   // x in the lowest bits
   typedef struct packed {
      coord_type w;
      coord_type z;
      coord_type y;
      coord_type x;
   } vertex_type;

   localparam plane_type PLANE_W_MINUS_X = 3'd0;
   localparam plane_type PLANE_W_PLUS_X  = 3'd1;
   localparam plane_type PLANE_W_MINUS_Y = 3'd2;
   localparam plane_type PLANE_W_PLUS_Y  = 3'd3;
   localparam plane_type PLANE_W_PLUS_Z  = 3'd4;
   localparam plane_type PLANE_W_MINUS_Z = 3'd5;

   localparam idx_type   LAST_SLOT   = idx_type'(MAX_VERTICES);
   localparam plane_type PLANE_LIMIT = plane_type'(PLANE_COUNT);

   typedef struct packed {
      logic      rd_en;
      logic      rd_buf;
      idx_type   rd_addr;
      logic      wr_in;
      logic      wr_tgt;
      logic      wr_cross;
      logic      wr_buf;
      idx_type   wr_addr;
      logic      latch_a;
      logic      cross_start;
      logic      out_load;
      logic      out_empty;
      logic      out_last;
      plane_type plane;
   } cmd_type;

   typedef struct packed {
      logic in_a;
      logic in_b;
      logic cross_done;
      logic cross_busy;
      logic out_busy;
   } stat_type;

   function automatic dist_type plane_dist(vertex_type v, plane_type p);
      dist_type w;
      dist_type x;
      dist_type y;
      dist_type z;
      w = dist_type'(v.w);
      x = dist_type'(v.x);
      y = dist_type'(v.y);
      z = dist_type'(v.z);
      case (p)
         PLANE_W_MINUS_X: return w - x;
         PLANE_W_PLUS_X:  return w + x;
         PLANE_W_MINUS_Y: return w - y;
         PLANE_W_PLUS_Y:  return w + y;
         PLANE_W_PLUS_Z:  return w + z;
         default:         return w - z;
      endcase
   endfunction

endpackage
`default_nettype wire

FILE: rtl/hgc_cross.sv
`default_nettype none
module hgc_cross (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire hgc_pkg::vertex_type a,
   input  wire hgc_pkg::vertex_type b,
   input  wire hgc_pkg::dist_type  da,
   input  wire hgc_pkg::dist_type  db,
   output logic                    busy,
   output logic                    done,
   output hgc_pkg::vertex_type     result
);
   import hgc_pkg::*;

   localparam int ACC_W = COORD_WIDTH + T_FRAC + 2;
   localparam int CNT_W = $clog2(T_FRAC + 1);
   localparam int MAG_W = COORD_WIDTH + 1;

   logic [MAG_W-1:0]   num;
   logic [MAG_W-1:0]   dbm;
   logic [MAG_W:0]     rem_ff, rem_in, den_ff, den_in;
   logic [MAG_W+1:0]   rem_sh;
   logic               qbit;
   logic               sat_ff, sat_in, busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   vertex_type         a_ff, a_in;
   logic [MAG_W-1:0]   mag_ff [4];
   logic [MAG_W-1:0]   mag_in [4];
   logic               neg_ff [4];
   logic               neg_in [4];
   logic [ACC_W-1:0]   acc_ff [4];
   logic [ACC_W-1:0]   acc_in [4];

   always_comb begin
      logic [MAG_W-1:0] diff;
      logic [MAG_W-1:0] step;
      logic [MAG_W-1:0] sum;
      diff   = '0;
      num    = da[COORD_WIDTH] ? MAG_W'(-da) : MAG_W'(da);
      dbm    = db[COORD_WIDTH] ? MAG_W'(-db) : MAG_W'(db);
      rem_sh = {rem_ff, 1'b0};
      qbit   = rem_sh >= {1'b0, den_ff};
      rem_in = rem_ff;
      den_in = den_ff;
      sat_in = sat_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in   = a_ff;
      result = a_ff;
      for (int k = 0; k < 4; k++) begin
         mag_in[k] = mag_ff[k];
         neg_in[k] = neg_ff[k];
         acc_in[k] = acc_ff[k];
         step = acc_ff[k][T_FRAC +: MAG_W];
         sum  = neg_ff[k] ? MAG_W'(a_ff[k*COORD_WIDTH +: COORD_WIDTH]) - step
                          : MAG_W'(a_ff[k*COORD_WIDTH +: COORD_WIDTH]) + step;
         result[k*COORD_WIDTH +: COORD_WIDTH] = sum[COORD_WIDTH-1:0];
      end
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = {1'b0, num} + {1'b0, dbm};
         sat_in  = dbm == '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         a_in    = a;
         for (int k = 0; k < 4; k++) begin
            diff = MAG_W'($signed(b[k*COORD_WIDTH +: COORD_WIDTH]))
                 - MAG_W'($signed(a[k*COORD_WIDTH +: COORD_WIDTH]));
            neg_in[k] = diff[MAG_W-1];
            mag_in[k] = diff[MAG_W-1] ? -diff : diff;
            acc_in[k] = '0;
         end
      end else if (busy_ff) begin
         if (sat_ff) begin
            for (int k = 0; k < 4; k++)
               acc_in[k] = ACC_W'(mag_ff[k]) << T_FRAC;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in = qbit ? (MAG_W+1)'(rem_sh - {1'b0, den_ff}) : rem_sh[MAG_W:0];
            for (int k = 0; k < 4; k++)
               acc_in[k] = {acc_ff[k][ACC_W-2:0], 1'b0}
                         + (qbit ? ACC_W'(mag_ff[k]) : '0);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(T_FRAC - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      for (int k = 0; k < 4; k++) begin
         mag_ff[k] <= mag_in[k];
         neg_ff[k] <= neg_in[k];
         acc_ff[k] <= acc_in[k];
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

FILE: rtl/hgc_datapath.sv
`default_nettype none
module hgc_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hgc_pkg::cmd_type    cmd,
   input  wire hgc_pkg::vertex_type in_vertex,
   input  wire logic                out_ready,
   output hgc_pkg::stat_type        stat,
   output hgc_pkg::vertex_type      out_vertex,
   output logic                     out_valid,
   output logic                     out_last,
   output logic                     out_empty
);
   import hgc_pkg::*;

   vertex_type mem0 [MAX_VERTICES];
   vertex_type mem1 [MAX_VERTICES];
   vertex_type rd_ff, a_ff, out_ff, wdata, cross_res;
   dist_type   da_ff, db;
   logic       we0, we1, cross_busy, cross_done;
   logic       out_valid_ff, out_last_ff, out_empty_ff;

   assign db    = plane_dist(rd_ff, cmd.plane);
   assign wdata = cmd.wr_in ? in_vertex : (cmd.wr_cross ? cross_res : rd_ff);
   assign we0   = cmd.wr_in | (cmd.wr_tgt & ~cmd.wr_buf);
   assign we1   = cmd.wr_tgt & cmd.wr_buf;

   hgc_cross u_cross (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.cross_start),
      .a      (a_ff),
      .b      (rd_ff),
      .da     (da_ff),
      .db     (db),
      .busy   (cross_busy),
      .done   (cross_done),
      .result (cross_res)
   );

   always_ff @(posedge clock) begin
      if (we0) mem0[cmd.wr_addr] <= wdata;
      if (we1) mem1[cmd.wr_addr] <= wdata;
      if (cmd.rd_en) rd_ff <= cmd.rd_buf ? mem1[cmd.rd_addr] : mem0[cmd.rd_addr];
      if (cmd.latch_a) begin
         a_ff  <= rd_ff;
         da_ff <= db;
      end
      if (cmd.out_load) begin
         out_ff       <= cmd.out_empty ? '0 : rd_ff;
         out_last_ff  <= cmd.out_last;
         out_empty_ff <= cmd.out_empty;
      end
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.out_load) out_valid_ff <= 1'b1;
      else if (out_ready) out_valid_ff <= 1'b0;
   end

   assign stat.in_a       = ~da_ff[COORD_WIDTH];
   assign stat.in_b       = ~db[COORD_WIDTH];
   assign stat.cross_done = cross_done;
   assign stat.cross_busy = cross_busy;
   assign stat.out_busy   = out_valid_ff;

   assign out_vertex = out_ff;
   assign out_valid  = out_valid_ff;
   assign out_last   = out_last_ff;
   assign out_empty  = out_empty_ff;

endmodule
`default_nettype wire

FILE: rtl/hgc_ctrl.sv
`default_nettype none
module hgc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic              in_last,
   output logic                   in_ready,
   input  wire hgc_pkg::stat_type stat,
   output hgc_pkg::cmd_type       cmd
);
   import hgc_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD, S_PASS, S_FIRST, S_EDGE, S_CROSS, S_KEEP, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] loaded_ff, loaded_in;
   idx_type    vcount_ff, vcount_in, i_ff, i_in, cnt_ff, cnt_in, emit_ff, emit_in;
   plane_type  plane_ff, plane_in;
   logic       sel_ff, sel_in;

   always_comb begin
      idx_type cnt_next;
      state_in  = state_ff;
      loaded_in = loaded_ff;
      vcount_in = vcount_ff;
      i_in      = i_ff;
      cnt_in    = cnt_ff;
      emit_in   = emit_ff;
      plane_in  = plane_ff;
      sel_in    = sel_ff;
      cnt_next  = cnt_ff;
      in_ready  = 1'b0;
      cmd       = '0;
      cmd.plane  = plane_ff;
      cmd.rd_buf = sel_ff;
      cmd.wr_buf = ~sel_ff;
      cmd.wr_addr = cnt_ff;
      case (state_ff)
         S_LOAD: begin
            in_ready = 1'b1;
            cmd.wr_addr = idx_type'(loaded_ff);
            if (in_valid) begin
               cmd.wr_in = 1'b1;
               if (in_last) begin
                  vcount_in = idx_type'(loaded_ff) + 1'b1;
                  loaded_in = '0;
                  plane_in  = '0;
                  sel_in    = 1'b0;
                  state_in  = S_PASS;
               end else if (loaded_ff != 2'd2) begin
                  loaded_in = loaded_ff + 1'b1;
               end
            end
         end
         S_PASS: begin
            cmd.rd_en = 1'b1;
            if (plane_ff == PLANE_LIMIT || vcount_ff == '0) begin
               cmd.rd_addr = '0;
               emit_in  = '0;
               state_in = S_EMIT;
            end else begin
               cmd.rd_addr = vcount_ff - 1'b1;
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            cmd.latch_a = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = '0;
            i_in     = '0;
            cnt_in   = '0;
            state_in = S_EDGE;
         end
         S_EDGE: begin
            if (stat.in_a != stat.in_b && cnt_ff < LAST_SLOT) begin
               cmd.cross_start = 1'b1;
               state_in = S_CROSS;
            end else begin
               state_in = S_KEEP;
            end
         end
         S_CROSS: begin
            if (stat.cross_done) begin
               cmd.wr_tgt   = 1'b1;
               cmd.wr_cross = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_KEEP;
            end
         end
         S_KEEP: begin
            if (stat.in_b && cnt_ff < LAST_SLOT) begin
               cmd.wr_tgt = 1'b1;
               cnt_next   = cnt_ff + 1'b1;
            end
            cnt_in = cnt_next;
            cmd.latch_a = 1'b1;
            if (i_ff == vcount_ff - 1'b1) begin
               vcount_in = cnt_next;
               sel_in    = ~sel_ff;
               plane_in  = plane_ff + 1'b1;
               state_in  = S_PASS;
            end else begin
               i_in        = i_ff + 1'b1;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = i_ff + 1'b1;
               state_in    = S_EDGE;
            end
         end
         S_EMIT: begin
            if (!stat.out_busy) begin
               cmd.out_load  = 1'b1;
               cmd.out_empty = vcount_ff == '0;
               cmd.out_last  = vcount_ff == '0 || emit_ff == vcount_ff - 1'b1;
               if (cmd.out_last) begin
                  state_in = S_LOAD;
               end else begin
                  emit_in     = emit_ff + 1'b1;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = emit_ff + 1'b1;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         loaded_ff <= '0;
         vcount_ff <= '0;
         i_ff      <= '0;
         cnt_ff    <= '0;
         emit_ff   <= '0;
         plane_ff  <= '0;
         sel_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
         vcount_ff <= vcount_in;
         i_ff      <= i_in;
         cnt_ff    <= cnt_in;
         emit_ff   <= emit_in;
         plane_ff  <= plane_in;
         sel_ff    <= sel_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/homogeneous_triangle_clipper_core.sv
`default_nettype none
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   req_tdata x,y,z,w; req_tlast closes triangle
// rsp      out  rsp_tvalid/rsp_tready   rsp_tdata x,y,z,w; rsp_tlast final; rsp_tuser empty
//
// a vertex that does not close a triangle is only stored
// a closing vertex runs up to six plane passes, fewer once the polygon is empty;
// each crossing goes through the shared 30-step divide/multiply unit, whose steps are
// skipped when the far end lies on the plane; emitted vertices are then held in turn
// until rsp_tready takes each one
// reset is synchronous; polygon stores need no clearing
// input is held off from the close until the last output vertex is registered
module homogeneous_triangle_clipper_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [4*hgc_pkg::COORD_WIDTH-1:0]   req_tdata,  // pos_x, pos_y, pos_z, pos_w
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [4*hgc_pkg::COORD_WIDTH-1:0]        rsp_tdata,  // out_x, out_y, out_z, out_w
   output logic                                     rsp_tlast,
   output logic [0:0]                               rsp_tuser   // fully_clipped
);
   import hgc_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   vertex_type out_vertex;
   logic       out_empty;

   hgc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_last  (req_tlast),
      .in_ready (req_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   hgc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_vertex  (vertex_type'(req_tdata)),
      .out_ready  (rsp_tready),
      .stat       (stat),
      .out_vertex (out_vertex),
      .out_valid  (rsp_tvalid),
      .out_last   (rsp_tlast),
      .out_empty  (out_empty)
   );

   assign rsp_tdata = out_vertex;
   assign rsp_tuser = out_empty;

   a_cross_on_change: assert property (@(posedge clock) disable iff (reset)
      cmd.cross_start |-> (stat.in_a != stat.in_b) && !stat.cross_busy)
      else $error("crossing started on an edge that does not cross");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_tvalid)
      else $error("output register overwritten");

   a_no_input_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !stat.cross_busy)
      else $error("input taken while a crossing is in flight");

endmodule
`default_nettype wire
